// ===== rtl/core/bole_pkg.sv =====
`default_nettype none
package bole_pkg;

    localparam int CAPACITY    = 16;
    localparam int VALUE_WIDTH = 32;

    // cell index and fill count widths
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

    typedef enum logic [2:0] {
        FN_HEAD   = 3'd0,
        FN_AT     = 3'd1,
        FN_APPEND = 3'd2,
        FN_SEARCH = 3'd3,
        FN_REMOVE = 3'd4
    } t_func;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    typedef enum logic [1:0] {
        CM_HOLD,
        CM_COMPARE,
        CM_INSERT,
        CM_REMOVE
    } t_cell_mode;

    typedef struct packed {
        t_cell_mode       mode;
        logic [CNT_W-1:0] pos;    // insert or removal slot
        logic [CNT_W-1:0] count;  // entries held before the operation
    } t_cell_ctrl;

endpackage
`default_nettype wire

// ===== rtl/core/bole_cell.sv =====
`default_nettype none
module bole_cell
    import bole_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic [IDX_W-1:0]       i_index,
    input  wire t_cell_ctrl             i_ctrl,
    input  wire logic [VALUE_WIDTH-1:0] i_key,
    input  wire logic [VALUE_WIDTH-1:0] i_left,
    input  wire logic [VALUE_WIDTH-1:0] i_right,
    output logic      [VALUE_WIDTH-1:0] o_value,
    output logic                        o_match
);

    logic [VALUE_WIDTH-1:0] r_value;
    logic                   r_match;
    logic [VALUE_WIDTH-1:0] n_value;
    logic                   n_match;
    logic [CNT_W-1:0]       idx;

    assign idx = CNT_W'(i_index);

    always_comb begin
        n_value = r_value;
        n_match = r_match;
        unique case (i_ctrl.mode)
            CM_HOLD: begin
            end
            CM_COMPARE: begin
                n_match = (r_value == i_key) && (idx < i_ctrl.count);
            end
            CM_INSERT: begin
                // open a gap at the slot: shift the upper part up by one
                if (idx > i_ctrl.pos) begin
                    n_value = i_left;
                end else if (idx == i_ctrl.pos) begin
                    n_value = i_key;
                end
            end
            CM_REMOVE: begin
                // close the gap: pull the upper part down by one
                if (idx >= i_ctrl.pos) begin
                    n_value = i_right;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_match <= n_match;
    end

    assign o_value = r_value;
    assign o_match = r_match;

endmodule
`default_nettype wire

// ===== rtl/core/bounded_ordered_list_engine.sv =====
`default_nettype none
// Channel   Dir  Transaction content
// s_axis    in   tuser: func[2:0]; tdata: value[31:0], position[36:32], zero fill to 40 bits
// m_axis    out  tuser: status[1:0]; tdata: hit_index[3:0], entry_count[8:4], zero fill
//
// A new transaction is taken only once the last one has left the apply cycle: accept,
// a compare cycle in which every cell checks its entry against the key, then an apply
// cycle that finds the first match and shifts the cells one place up or down in parallel.
// The result is registered when the apply cycle completes, whatever the fill of the list.
// Reset clears the entry count and the control state; cell contents stay as they are.
// A stalled result holds the next apply cycle; the next input may still be taken.
module bounded_ordered_list_engine
    import bole_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // value[31:0], position[36:32]
    input  wire logic [2:0]  s_axis_tuser,   // func[2:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [15:0] m_axis_tdata,   // hit_index[3:0], entry_count[8:4]
    output logic      [1:0]  m_axis_tuser    // status[1:0]
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_APPLY
    } t_state;

    t_state r_state;
    logic [2:0]  r_func;
    logic [31:0] r_value;
    logic [4:0]  r_pos;
    logic [CNT_W-1:0] r_count;
    logic        r_out_valid;
    logic [1:0]  r_out_status;
    logic [3:0]  r_out_hit;
    logic [4:0]  r_out_count;

    logic [VALUE_WIDTH-1:0] key;
    logic [VALUE_WIDTH-1:0] cell_value [CAPACITY];
    logic [CAPACITY-1:0]    cell_match;
    t_cell_ctrl             ctrl;

    logic             accept;
    logic             apply_go;
    logic             is_insert;
    logic             is_lookup;
    logic             full;
    logic             found;
    logic [IDX_W-1:0] hit_idx;
    logic [CNT_W-1:0] ins_pos;
    logic [1:0]       status;
    logic [CNT_W-1:0] n_count;

    assign key           = VALUE_WIDTH'(r_value);
    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign apply_go      = (r_state == S_APPLY) && (!r_out_valid || m_axis_tready);

    assign is_insert = (r_func == FN_HEAD) || (r_func == FN_AT) || (r_func == FN_APPEND);
    assign is_lookup = (r_func == FN_SEARCH) || (r_func == FN_REMOVE);
    assign full      = (r_count == FULL_COUNT);

    // first matching cell, lowest index wins
    always_comb begin
        found   = 1'b0;
        hit_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (cell_match[i]) begin
                found   = 1'b1;
                hit_idx = IDX_W'(i);
            end
        end
    end

    // insert slot; a position at or past the tail appends
    always_comb begin
        unique case (r_func)
            FN_HEAD: ins_pos = '0;
            FN_AT: begin
                if ((CNT_W + 5)'(r_pos) >= (CNT_W + 5)'(r_count)) begin
                    ins_pos = r_count;
                end else begin
                    ins_pos = CNT_W'(r_pos);
                end
            end
            default: ins_pos = r_count;
        endcase
    end

    always_comb begin
        ctrl.mode  = CM_HOLD;
        ctrl.pos   = ins_pos;
        ctrl.count = r_count;
        status     = ST_OK;
        n_count    = r_count;
        if (r_state == S_CMP) begin
            ctrl.mode = CM_COMPARE;
        end
        if (is_insert) begin
            if (full) begin
                status = ST_FULL;
            end else if (apply_go) begin
                ctrl.mode = CM_INSERT;
                n_count   = r_count + 1'b1;
            end
        end else if (is_lookup) begin
            if (!found) begin
                status = ST_NOT_FOUND;
            end else if (r_func == FN_REMOVE) begin
                ctrl.pos = CNT_W'(hit_idx);
                n_count  = r_count - 1'b1;
                if (apply_go) begin
                    ctrl.mode = CM_REMOVE;
                end
            end
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [VALUE_WIDTH-1:0] left;
        logic [VALUE_WIDTH-1:0] right;
        if (g == 0) begin : g_first
            assign left = key;
        end else begin : g_inner_l
            assign left = cell_value[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign right = key;
        end else begin : g_inner_r
            assign right = cell_value[g+1];
        end
        bole_cell u_cell (
            .i_clk   (i_clk),
            .i_index (IDX_W'(g)),
            .i_ctrl  (ctrl),
            .i_key   (key),
            .i_left  (left),
            .i_right (right),
            .o_value (cell_value[g]),
            .o_match (cell_match[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (m_axis_tready && !apply_go) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_state <= S_APPLY;
                end
                S_APPLY: begin
                    // hold here until the output register is free
                    if (apply_go) begin
                        r_state     <= S_IDLE;
                        r_count     <= n_count;
                        r_out_valid <= 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
        // payload registers
        if (accept) begin
            r_func  <= s_axis_tuser;
            r_value <= s_axis_tdata[31:0];
            r_pos   <= s_axis_tdata[36:32];
        end
        if (apply_go) begin
            r_out_status <= status;
            r_out_hit    <= (is_lookup && found) ? 4'(hit_idx) : 4'd0;
            r_out_count  <= 5'(n_count);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {7'd0, r_out_count, r_out_hit};

    // fill count never passes the capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("entry count above capacity");

    // a refused insert only happens on a full list and leaves it full
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        apply_go && status == ST_FULL |=> r_count == FULL_COUNT)
        else $error("full status with a list that is not full");

    // a successful removal shrinks the list by one
    a_remove_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        apply_go && r_func == FN_REMOVE && found |=> r_count == $past(r_count) - 1'b1)
        else $error("removal did not shrink the list");

    // no new input while an item is in flight
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !s_axis_tready)
        else $error("input taken while busy");

endmodule
`default_nettype wire

// ===== tb/tb_bounded_ordered_list_engine.sv =====
`default_nettype none
// Self-checking bench for the ordered list engine. A queue of list operations
// feeds a stream driver; each accepted transaction runs through a shadow list
// that yields the expected result, and a monitor checks every result
// transaction against the oldest expectation.
module tb_bounded_ordered_list_engine;
    import bole_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // func codes the block must treat as no-ops
    localparam logic [2:0] FN_RSVD5 = 3'd5;
    localparam logic [2:0] FN_RSVD6 = 3'd6;
    localparam logic [2:0] FN_RSVD7 = 3'd7;

    localparam int RANDOM_OPS    = 1725;
    localparam int SEGMENT_LEN   = 40;
    localparam int QUIET_FIRST   = 900;   // no idling on either side in this window
    localparam int QUIET_LAST    = 1150;
    localparam int HOLD_AFTER    = 400;   // results seen before the long receiver hold
    localparam int HOLD_CYCLES   = 250;
    localparam int IDLE_PERCENT  = 35;
    localparam int SETTLE_CYCLES = 12;

    typedef struct {
        logic [2:0]             func;
        logic [VALUE_WIDTH-1:0] value;
        logic [4:0]             position;
        bit                     drain_first;  // wait for all results before offering
    } list_op_t;

    typedef struct {
        logic [1:0] status;
        logic [3:0] hit_index;
        logic [4:0] entry_count;
    } list_result_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;   // value[31:0], position[36:32]
    logic [2:0]  s_axis_tuser = '0;   // func[2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // hit_index[3:0], entry_count[8:4]
    logic [1:0]  m_axis_tuser;        // status[1:0]

    list_op_t     pending_ops[$];
    list_result_t expected_results[$];

    // shadow copy of the list contents
    logic [VALUE_WIDTH-1:0] shadow_list [CAPACITY];
    int                     shadow_count = 0;

    logic [VALUE_WIDTH-1:0] value_pool [8];

    logic op_taken = 1'b0;
    int   ops_taken = 0;
    int   results_seen = 0;
    int   fail_count = 0;
    int   hold_left = 0;
    bit   hold_done = 1'b0;

    bounded_ordered_list_engine DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Apply one operation to the shadow list and queue the result it must give.
    task automatic apply_list_op(input list_op_t op);
        list_result_t res;
        int           slot;
        int           idx;
        int           k;
        res.status      = ST_OK;
        res.hit_index   = '0;
        res.entry_count = '0;
        case (op.func)
            FN_HEAD, FN_AT, FN_APPEND: begin
                if (shadow_count >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    if (op.func == FN_HEAD)
                        slot = 0;
                    else if (op.func == FN_AT)
                        slot = int'(op.position);
                    else
                        slot = shadow_count;
                    // a position past the tail means append
                    if (slot > shadow_count)
                        slot = shadow_count;
                    for (k = shadow_count; k > slot; k--)
                        shadow_list[k] = shadow_list[k-1];
                    shadow_list[slot] = op.value;
                    shadow_count++;
                end
            end
            FN_SEARCH, FN_REMOVE: begin
                idx = shadow_count;
                for (k = shadow_count - 1; k >= 0; k--)
                    if (shadow_list[k] == op.value)
                        idx = k;
                if (idx >= shadow_count) begin
                    res.status = ST_NOT_FOUND;
                end else begin
                    res.hit_index = 4'(idx);
                    if (op.func == FN_REMOVE) begin
                        // close the gap
                        for (k = idx; k + 1 < shadow_count; k++)
                            shadow_list[k] = shadow_list[k+1];
                        shadow_count--;
                    end
                end
            end
            default: ;  // unknown func: list unchanged
        endcase
        res.entry_count = 5'(shadow_count);
        expected_results.push_back(res);
    endtask

    task automatic queue_op(input logic [2:0] func, input logic [31:0] value,
                            input logic [4:0] position, input bit drain_first);
        list_op_t op;
        op.func        = func;
        op.value       = value;
        op.position    = position;
        op.drain_first = drain_first;
        pending_ops.push_back(op);
    endtask

    // Note acceptance of an input transaction at the rising edge.
    always @(posedge i_clk)
        op_taken <= s_axis_tvalid && s_axis_tready;

    // Driver: predict the transaction just taken, then hold or offer the next one.
    always @(negedge i_clk) begin
        bit offer;
        if (i_rst_n) begin
            if (op_taken) begin
                apply_list_op(pending_ops.pop_front());
                ops_taken++;
            end
            if (!(s_axis_tvalid && !op_taken)) begin
                offer = 1'b0;
                if (pending_ops.size() != 0) begin
                    if (pending_ops[0].drain_first && expected_results.size() != 0)
                        offer = 1'b0;
                    else if (ops_taken >= QUIET_FIRST && ops_taken < QUIET_LAST)
                        offer = 1'b1;
                    else
                        offer = ($urandom_range(0, 99) >= IDLE_PERCENT);
                end
                s_axis_tvalid <= offer;
                if (offer) begin
                    s_axis_tdata <= {3'b000, pending_ops[0].position, pending_ops[0].value};
                    s_axis_tuser <= pending_ops[0].func;
                end
            end
        end
    end

    // Receiver: random backpressure, one long hold so the block fills and stalls.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left--;
        end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end else if (results_seen >= QUIET_FIRST && results_seen < QUIET_LAST) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    // Monitor: check each result transaction against the oldest expectation.
    always @(posedge i_clk) begin
        list_result_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0) begin
                $error("unexpected result: status %0d hit_index %0d entry_count %0d",
                       m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[8:4]);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (m_axis_tuser !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, m_axis_tuser);
                    fail_count++;
                end
                if (m_axis_tdata[3:0] !== want.hit_index) begin
                    $error("hit_index: expected %0d, actual %0d",
                           want.hit_index, m_axis_tdata[3:0]);
                    fail_count++;
                end
                if (m_axis_tdata[8:4] !== want.entry_count) begin
                    $error("entry_count: expected %0d, actual %0d",
                           want.entry_count, m_axis_tdata[8:4]);
                    fail_count++;
                end
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        int          i;
        int          roll;
        int          segment;
        logic [2:0]  func;
        logic [31:0] value;
        logic [4:0]  position;

        value_pool[0] = 32'h0000_0000;
        value_pool[1] = 32'h7fff_ffff;
        value_pool[2] = 32'h8000_0000;
        value_pool[3] = 32'hffff_ffff;
        for (i = 4; i < 8; i++)
            value_pool[i] = $urandom;

        // directed: empty list, extremes, mid insert, past-tail insert,
        // duplicates, first-match removal, unknown funcs
        queue_op(FN_SEARCH, 32'h0000_0000, 5'd0,  1'b0);
        queue_op(FN_REMOVE, 32'h0000_0000, 5'd0,  1'b0);
        queue_op(FN_RSVD7,  32'hffff_ffff, 5'd31, 1'b0);
        queue_op(FN_HEAD,   32'h7fff_ffff, 5'd31, 1'b0);
        queue_op(FN_HEAD,   32'h8000_0000, 5'd0,  1'b0);
        queue_op(FN_APPEND, 32'h0000_0000, 5'd17, 1'b0);
        queue_op(FN_APPEND, 32'hffff_ffff, 5'd0,  1'b0);
        queue_op(FN_AT,     32'h0000_0005, 5'd1,  1'b0);
        queue_op(FN_AT,     32'h0000_0005, 5'd31, 1'b0);
        queue_op(FN_AT,     32'h0000_007b, 5'd0,  1'b0);
        queue_op(FN_AT,     32'h5555_aaaa, 5'd16, 1'b0);
        queue_op(FN_SEARCH, 32'h0000_0005, 5'd0,  1'b0);
        queue_op(FN_SEARCH, 32'h7fff_ffff, 5'd0,  1'b0);
        queue_op(FN_SEARCH, 32'h0000_002a, 5'd0,  1'b0);
        queue_op(FN_REMOVE, 32'h0000_0005, 5'd0,  1'b0);
        queue_op(FN_SEARCH, 32'h0000_0005, 5'd0,  1'b0);
        queue_op(FN_REMOVE, 32'h8000_0000, 5'd0,  1'b0);
        queue_op(FN_REMOVE, 32'h0000_002a, 5'd0,  1'b0);
        queue_op(FN_RSVD5,  32'h0000_0001, 5'd1,  1'b0);
        queue_op(FN_RSVD6,  32'haaaa_5555, 5'd10, 1'b0);

        // random: segments that lean toward filling, draining, or a mix, so the
        // list reaches full and empty repeatedly
        for (i = 0; i < RANDOM_OPS; i++) begin
            segment = (i / SEGMENT_LEN) % 3;
            roll = $urandom_range(0, 99);
            if (roll < 4)
                func = 3'($urandom_range(5, 7));
            else if ((segment == 0 && roll < 75) || (segment == 1 && roll < 20)
                     || (segment == 2 && roll < 50))
                func = 3'($urandom_range(FN_HEAD, FN_APPEND));
            else
                func = ($urandom_range(0, 1) != 0) ? 3'(FN_REMOVE) : 3'(FN_SEARCH);
            value = ($urandom_range(0, 3) != 0) ? value_pool[$urandom_range(0, 7)]
                                                : 32'($urandom);
            position = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                                   : 5'($urandom_range(0, 17));
            queue_op(func, value, position, (i == 0 || i == 600 || i == 1300));
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_ops.size() != 0 || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("tb_bounded_ordered_list_engine passed");
        end else begin
            $display("tb_bounded_ordered_list_engine failed");
        end
        $finish;
    end

    // Hard stop if the handshakes ever hang.
    initial begin
        #3_000_000;
        $display("tb_bounded_ordered_list_engine failed");
        $finish;
    end

endmodule
`default_nettype wire
